[rtl/core/cps_pkg.sv]
// Shared types, codes and sizes for the convex polygon scanline span block.
// Used by cps_div, cps_sort and the top level in rtl/core; depends on nothing.
package cps_pkg;

  // vertex list
  localparam int MAX_VERTICES = 8;
  localparam int VERT_AW      = 3;
  localparam int CNT_W        = 4;

  // crossing list
  localparam int MAX_CROSS    = 8;

  // pixel coordinates, signed
  localparam int PIX_W        = 13;
  localparam logic [PIX_W-1:0] PIX_BIAS = 13'd2048;

  // shared multiplier and iterative divider
  localparam int MUL_A_W      = 19;
  localparam int MUL_B_W      = 18;
  localparam int PROD_W       = 37;
  localparam int NUM_W        = 38;
  localparam int QUO_BITS     = 13;
  localparam int REM_W        = 36;
  localparam int DIV_W        = 22;
  localparam int STEP_W       = 4;

  // input item modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  // unused mode: answered like a clear, state untouched
  localparam logic [1:0] MODE_NOP    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_FIRST,
    ST_EDGE,
    ST_TEST,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_INS,
    ST_NEXT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop_pair;
  } sort_ctrl_t;

endpackage

[rtl/core/cps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the vertex store.
module cps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cps_div.sv]
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in QUO_BITS unsigned bits. Depends on cps_pkg.
module cps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cps_pkg::REM_W-1:0]   dividend,
  input  logic [cps_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [cps_pkg::QUO_BITS-1:0] quotient
);

  logic                         busy;
  logic [cps_pkg::STEP_W-1:0]   step;
  logic [cps_pkg::REM_W-1:0]    rem;
  logic [cps_pkg::REM_W-1:0]    dsh;
  logic                         fits;

  assign fits = (rem >= dsh);

  // control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= cps_pkg::STEP_W'(cps_pkg::QUO_BITS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract, shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= cps_pkg::REM_W'({divisor, {(cps_pkg::QUO_BITS-1){1'b0}}});
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[cps_pkg::QUO_BITS-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

endmodule

[rtl/core/cps_sort.sv]
// Sorted crossing list: a row of cells that inserts one value per cycle in
// ascending order and pops the two smallest. Depends on cps_pkg.
module cps_sort (
  input  logic                              clk,
  input  logic                              rst,
  input  cps_pkg::sort_ctrl_t               ctrl,
  input  logic signed [cps_pkg::PIX_W-1:0]  din,
  output logic signed [cps_pkg::PIX_W-1:0]  head0,
  output logic signed [cps_pkg::PIX_W-1:0]  head1,
  output logic [cps_pkg::CNT_W-1:0]         count
);

  logic signed [cps_pkg::PIX_W-1:0] val [cps_pkg::MAX_CROSS];
  logic [cps_pkg::MAX_CROSS-1:0]    gt;

  assign head0 = val[0];
  assign head1 = val[1];

  // cells holding a value above the new one move up
  always_comb begin
    for (int j = 0; j < cps_pkg::MAX_CROSS; j++) begin
      gt[j] = (cps_pkg::CNT_W'(j) < count) && (val[j] > din);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.insert) begin
      count <= count + 1'b1;
    end else if (ctrl.pop_pair) begin
      count <= count - 2'd2;
    end
  end

  // insert in order, or shift down by two
  always_ff @(posedge clk) begin
    for (int j = 0; j < cps_pkg::MAX_CROSS; j++) begin
      if (ctrl.insert) begin
        if (gt[j] || (cps_pkg::CNT_W'(j) == count)) begin
          if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
            val[j] <= val[(j > 0) ? j - 1 : 0];
          end else begin
            val[j] <= din;
          end
        end
      end else if (ctrl.pop_pair && (j + 2 < cps_pkg::MAX_CROSS)) begin
        val[j] <= val[(j + 2 < cps_pkg::MAX_CROSS) ? j + 2 : j];
      end
    end
  end

endmodule

[rtl/core/convex_polygon_scanline_spans.sv]
// Top level of the polygon scanline span block: sequencer, edge datapath with
// one shared multiplier, the iterative divider and the sorted crossing list.
// Depends on cps_pkg, cps_ram, cps_div and cps_sort.
//
// Clear (mode 0) and append (mode 1) each give one result. A row query
// (mode 2) reads the vertex list from a RAM one vertex per edge and walks
// the closed edges in order; an edge that crosses the row centre makes two
// passes through the shared multiplier, then waits on the one-bit-per-cycle
// divider, then is inserted into the sorted list, while an edge that misses
// it skips those steps. The divider dominates the time of a query. The
// input is not ready while a query runs; a finished result waits in the
// output register and does not hold up the next input transfer.
module convex_polygon_scanline_spans (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // vertex_x[15:0], vertex_y[31:16], row[44:32], zero
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // first_row, final_row, span_start, span_end, zero
  output logic [1:0]  m_tuser,  // span_valid[0], overflow[1]
  output logic        m_tlast   // last_result
);

  localparam int PW = cps_pkg::PIX_W;

  cps_pkg::state_t state, state_next;

  // input fields
  logic [1:0]          in_mode;
  logic signed [15:0]  in_x, in_y;
  logic signed [PW-1:0] in_row;
  logic                s_xfer;

  assign in_mode = s_tuser;
  assign in_x    = s_tdata[15:0];
  assign in_y    = s_tdata[31:16];
  assign in_row  = s_tdata[44:32];
  assign s_xfer  = s_tvalid && s_tready;

  // polygon state
  logic [cps_pkg::CNT_W-1:0] vcount;
  logic signed [15:0]        min_y, max_y;
  logic                      ovf;

  // edge datapath registers
  logic signed [17:0]               yc2;
  logic signed [15:0]               ax, ay, bx, by, fx, fy;
  logic [cps_pkg::CNT_W-1:0]        edge_i;
  logic signed [cps_pkg::PROD_W-1:0] prod, acc;
  logic signed [cps_pkg::NUM_W-1:0]  num;
  logic [16:0]                      absdy;

  // combinational edge terms
  logic signed [16:0] ay2, by2;
  logic signed [17:0] dy2;
  logic signed [18:0] tt;
  logic signed [16:0] dx;
  logic               crosses;
  logic signed [cps_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cps_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cps_pkg::NUM_W-1:0]   sum;
  logic [38:0]                        nbias;
  logic [cps_pkg::CNT_W-1:0]          edge_p1, edge_p2;
  logic                               wrap;

  // memory and units
  logic                          ram_we;
  logic [cps_pkg::VERT_AW-1:0]   ram_raddr;
  logic [31:0]                   ram_rdata;
  logic                          div_start, div_done;
  logic [cps_pkg::QUO_BITS-1:0]  div_q;
  logic signed [PW-1:0]          xpix;
  cps_pkg::sort_ctrl_t           sctrl;
  logic signed [PW-1:0]          head0, head1;
  logic [cps_pkg::CNT_W-1:0]     scount;

  // output register
  logic                 out_free, out_load;
  logic signed [PW-1:0] o_first, o_final, o_start, o_end;
  logic                 o_valid, o_last, o_ovf;
  logic signed [PW-1:0] cur_first, cur_final;
  logic signed [16:0]   max_up;
  logic                 emit_done;

  assign ay2     = {ay, 1'b0};
  assign by2     = {by, 1'b0};
  assign dy2     = 18'(by2) - 18'(ay2);
  assign tt      = 19'(yc2) - 19'(ay2);
  assign dx      = 17'(bx) - 17'(ax);
  assign crosses = ((18'(ay2) <= yc2) && (18'(by2) > yc2)) ||
                   ((18'(by2) <= yc2) && (18'(ay2) > yc2));
  assign edge_p1 = edge_i + 1'b1;
  assign edge_p2 = edge_i + 2'd2;
  assign wrap    = (edge_p1 == vcount);

  // shared multiplier operands: x * dy first, then t * dx
  assign mul_a = (state == cps_pkg::ST_MUL1) ? 19'(ax) : tt;
  assign mul_b = (state == cps_pkg::ST_MUL1) ? dy2 : 18'(dx);

  // numerator, sign folded so the denominator is positive
  assign sum   = 38'(acc) + 38'(prod);
  // biased dividend 2*num + den + 4096*den with den = |dy| * 16
  assign nbias = {num, 1'b0} + 39'({absdy, 16'b0}) + 39'({absdy, 4'b0});
  assign xpix  = div_q - cps_pkg::PIX_BIAS;

  // row range of the current list
  assign max_up    = 17'(max_y) + 17'sd15;
  assign cur_first = (vcount == '0) ? '0 : {min_y[15], min_y[15:4]};
  assign cur_final = (vcount == '0) ? '0 : max_up[16:4];

  assign out_free  = !m_tvalid || m_tready;
  assign emit_done = out_free && (scount < 4'd4);

  cps_ram #(
    .WIDTH (32),
    .DEPTH (cps_pkg::MAX_VERTICES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vcount[cps_pkg::VERT_AW-1:0]),
    .wdata ({in_y, in_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nbias[cps_pkg::REM_W-1:0]),
    .divisor  ({absdy, 5'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  cps_sort u_sort (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sctrl),
    .din   (xpix),
    .head0 (head0),
    .head1 (head1),
    .count (scount)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        if (s_xfer) begin
          if (in_mode == cps_pkg::MODE_QUERY) begin
            state_next = (vcount < 4'd2) ? cps_pkg::ST_EMIT : cps_pkg::ST_FIRST;
          end else begin
            state_next = cps_pkg::ST_RESP;
          end
        end
      end
      cps_pkg::ST_RESP:  if (out_free) state_next = cps_pkg::ST_IDLE;
      cps_pkg::ST_FIRST: state_next = cps_pkg::ST_EDGE;
      cps_pkg::ST_EDGE:  state_next = cps_pkg::ST_TEST;
      cps_pkg::ST_TEST:  state_next = crosses ? cps_pkg::ST_MUL1 : cps_pkg::ST_NEXT;
      cps_pkg::ST_MUL1:  state_next = cps_pkg::ST_MUL2;
      cps_pkg::ST_MUL2:  state_next = cps_pkg::ST_SUM;
      cps_pkg::ST_SUM:   state_next = cps_pkg::ST_PREP;
      cps_pkg::ST_PREP:  state_next = cps_pkg::ST_DIV;
      cps_pkg::ST_DIV:   if (div_done) state_next = cps_pkg::ST_INS;
      cps_pkg::ST_INS:   state_next = cps_pkg::ST_NEXT;
      cps_pkg::ST_NEXT: begin
        if (wrap || (scount == 4'(cps_pkg::MAX_CROSS))) begin
          state_next = cps_pkg::ST_EMIT;
        end else begin
          state_next = cps_pkg::ST_EDGE;
        end
      end
      cps_pkg::ST_EMIT:  if (emit_done) state_next = cps_pkg::ST_IDLE;
      default:           state_next = cps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready     = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = '0;
    div_start    = 1'b0;
    sctrl        = '0;
    out_load     = 1'b0;
    o_start      = '0;
    o_end        = '0;
    o_valid      = 1'b0;
    o_ovf        = 1'b0;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        ram_we      = s_xfer && (in_mode == cps_pkg::MODE_APPEND) &&
                      (vcount < 4'(cps_pkg::MAX_VERTICES));
        sctrl.clear = s_xfer;
      end
      cps_pkg::ST_RESP: begin
        out_load = out_free;
        o_ovf    = ovf;
      end
      cps_pkg::ST_FIRST: ram_raddr = 3'd1;
      cps_pkg::ST_PREP:  div_start = 1'b1;
      cps_pkg::ST_INS:   sctrl.insert = 1'b1;
      cps_pkg::ST_NEXT:  ram_raddr = edge_p2[cps_pkg::VERT_AW-1:0];
      cps_pkg::ST_EMIT: begin
        out_load = out_free;
        if (scount >= 4'd2) begin
          o_start        = head0;
          o_end          = head1;
          o_valid        = 1'b1;
          sctrl.pop_pair = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cps_pkg::ST_IDLE;
      vcount <= '0;
      min_y  <= '0;
      max_y  <= '0;
      ovf    <= 1'b0;
    end else begin
      state <= state_next;
      if (s_xfer) begin
        ovf <= 1'b0;
        if (in_mode == cps_pkg::MODE_CLEAR) begin
          vcount <= '0;
          min_y  <= '0;
          max_y  <= '0;
        end else if (in_mode == cps_pkg::MODE_APPEND) begin
          if (vcount >= 4'(cps_pkg::MAX_VERTICES)) begin
            ovf <= 1'b1;
          end else begin
            vcount <= vcount + 1'b1;
            if (vcount == '0 || in_y < min_y) min_y <= in_y;
            if (vcount == '0 || in_y > max_y) max_y <= in_y;
          end
        end
      end
    end
  end

  // edge datapath
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      yc2    <= {in_row, 1'b1, 4'b0};
      edge_i <= '0;
    end
    unique case (state)
      cps_pkg::ST_FIRST: begin
        ax <= ram_rdata[15:0];
        ay <= ram_rdata[31:16];
        fx <= ram_rdata[15:0];
        fy <= ram_rdata[31:16];
      end
      cps_pkg::ST_EDGE: begin
        bx <= wrap ? fx : ram_rdata[15:0];
        by <= wrap ? fy : ram_rdata[31:16];
      end
      cps_pkg::ST_MUL1: prod <= 37'(mul_a) * 37'(mul_b);
      cps_pkg::ST_MUL2: begin
        acc  <= prod;
        prod <= 37'(mul_a) * 37'(mul_b);
      end
      cps_pkg::ST_SUM: begin
        num   <= dy2[17] ? -sum : sum;
        absdy <= dy2[17] ? 17'(-dy2) : 17'(dy2);
      end
      cps_pkg::ST_NEXT: begin
        ax     <= bx;
        ay     <= by;
        edge_i <= edge_p1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, o_end, o_start, cur_final, cur_first};
      m_tuser <= {o_ovf, o_valid};
      m_tlast <= (state == cps_pkg::ST_RESP) || (scount < 4'd4);
    end
  end

  // checks
  a_vcount_max: assert property (@(posedge clk) disable iff (rst)
    vcount <= 4'(cps_pkg::MAX_VERTICES))
    else $error("vertex count beyond list size");

  a_scount_max: assert property (@(posedge clk) disable iff (rst)
    scount <= 4'(cps_pkg::MAX_CROSS))
    else $error("crossing count beyond list size");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("result without a span is not the last one");

  a_ovf_nospan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("overflow result carries a span");

endmodule

[tb/convex_polygon_scanline_spans_tb.sv]
// Self-checking testbench for the polygon scanline span block: builds random
// polygons, queries rows, and checks every span against its own predictor.
// Depends on cps_pkg and convex_polygon_scanline_spans.
module convex_polygon_scanline_spans_tb;
  import cps_pkg::*;

  typedef struct packed {
    logic signed [12:0] first_row;
    logic signed [12:0] final_row;
    logic signed [12:0] span_start;
    logic signed [12:0] span_end;
    logic               span_valid;
    logic               last_result;
    logic               overflow;
  } span_rec_t;

  // Span predictor and store of expected results
  class span_scoreboard;
    logic signed [15:0] vx[MAX_VERTICES];
    logic signed [15:0] vy[MAX_VERTICES];
    int                 count;
    longint             lo_y;
    longint             hi_y;
    span_rec_t          pending[$];
    int                 errors;
    int                 matched;
    int                 spans;
    int                 overflows;

    function new();
      count = 0;
      lo_y = 0;
      hi_y = 0;
      errors = 0;
      matched = 0;
      spans = 0;
      overflows = 0;
    endfunction

    // floor division for a positive divisor
    function longint fdiv(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint clamp(longint v);
      if (v < -2048) return -2048;
      if (v > 2048) return 2048;
      return v;
    endfunction

    function void push(longint s, longint e, bit v, bit l, bit o);
      span_rec_t r;
      r.first_row = (count > 0) ? 13'(clamp(fdiv(lo_y, 16))) : 13'd0;
      r.final_row = (count > 0) ? 13'(clamp(-fdiv(-hi_y, 16))) : 13'd0;
      r.span_start = 13'(s);
      r.span_end = 13'(e);
      r.span_valid = v;
      r.last_result = l;
      r.overflow = o;
      pending = {pending, r};
    endfunction

    // note an accepted input transfer and predict its results
    function void note(logic [1:0] mode, logic signed [15:0] x, logic signed [15:0] y,
                       logic signed [12:0] row);
      longint xs[MAX_CROSS];
      longint yc2, ax, ay2, bx, by2, num, den, t;
      int     m, nx, j, pairs;
      m = 0;
      if (mode == MODE_CLEAR) begin
        count = 0;
        lo_y = 0;
        hi_y = 0;
        push(0, 0, 0, 1, 0);
      end else if (mode == MODE_APPEND) begin
        if (count >= MAX_VERTICES) begin
          overflows++;
          push(0, 0, 0, 1, 1);
        end else begin
          vx[count] = x;
          vy[count] = y;
          if (count == 0 || y < lo_y) lo_y = y;
          if (count == 0 || y > hi_y) hi_y = y;
          count++;
          push(0, 0, 0, 1, 0);
        end
      end else if (mode != MODE_QUERY) begin
        push(0, 0, 0, 1, 0);
      end else begin
        yc2 = (2 * longint'(row) + 1) * 16;
        for (int i = 0; i < count && m < MAX_CROSS; i++) begin
          nx = (i + 1 < count) ? i + 1 : 0;
          ax = vx[i];
          ay2 = 2 * longint'(vy[i]);
          bx = vx[nx];
          by2 = 2 * longint'(vy[nx]);
          if ((ay2 <= yc2 && by2 > yc2) || (by2 <= yc2 && ay2 > yc2)) begin
            num = ax * (by2 - ay2) + (yc2 - ay2) * (bx - ax);
            den = (by2 - ay2) * 16;
            if (den < 0) begin
              num = -num;
              den = -den;
            end
            xs[m] = clamp(fdiv(2 * num + den, 2 * den));
            m++;
          end
        end
        // insertion sort of the crossings
        for (int i = 1; i < m; i++) begin
          t = xs[i];
          j = i - 1;
          while (j >= 0 && xs[j] > t) begin
            xs[j + 1] = xs[j];
            j--;
          end
          xs[j + 1] = t;
        end
        pairs = m / 2;
        if (pairs == 0) push(0, 0, 0, 1, 0);
        for (int i = 0; i < pairs; i++) begin
          push(xs[2 * i], xs[2 * i + 1], 1, i == pairs - 1, 0);
          spans++;
        end
      end
    endfunction

    // compare one output transfer with the oldest expectation
    function void check(span_rec_t got);
      span_rec_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: start %0d end %0d",
                                   got.span_start, got.span_end);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rows %0d..%0d span %0d..%0d v%0b l%0b o%0b, got rows %0d..%0d span %0d..%0d v%0b l%0b o%0b",
                   want.first_row, want.final_row, want.span_start, want.span_end,
                   want.span_valid, want.last_result, want.overflow,
                   got.first_row, got.final_row, got.span_start, got.span_end,
                   got.span_valid, got.last_result, got.overflow);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  span_scoreboard sb;
  bit          calm;
  bit          hold_req;
  int          items_sent;
  int          quiet_cycles;

  convex_polygon_scanline_spans u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= (calm || $urandom_range(0, 99) >= 27);
    end
  end

  // check every output transfer
  always @(posedge clk) begin
    span_rec_t r;
    if (!rst && m_tvalid && m_tready) begin
      r.first_row = m_tdata[12:0];
      r.final_row = m_tdata[25:13];
      r.span_start = m_tdata[38:26];
      r.span_end = m_tdata[51:39];
      r.span_valid = m_tuser[0];
      r.overflow = m_tuser[1];
      r.last_result = m_tlast;
      sb.check(r);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // offer one item, idling at random first; entered and left at a falling edge
  task send_item(logic [1:0] mode, logic signed [15:0] x, logic signed [15:0] y,
                 logic signed [12:0] row);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {3'b000, row, y, x};
    do @(posedge clk); while (!s_tready);
    sb.note(mode, x, y, row);
    items_sent++;
    @(negedge clk);
  endtask

  task append(int x, int y);
    send_item(MODE_APPEND, x, y, $urandom);
  endtask

  task query(int row);
    send_item(MODE_QUERY, $urandom, $urandom, row);
  endtask

  initial begin
    int cx, cy, rad, nv, nq;
    bit wide;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_CLEAR;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, one vertex, two vertices, triangle, overflow
    query(0);
    append(16, 16);
    query(1);
    append(160, 80);
    query(3);
    append(-32768, 32767);
    query(-2048);
    query(2048);
    query(4);
    send_item(MODE_CLEAR, 0, 0, 0);
    // triangle plus edge-exact rows
    append(0, 0);
    append(320, 0);
    append(160, 160);
    query(0);
    query(5);
    query(9);
    query(-1);
    send_item(MODE_NOP, -1, -1, -1);
    for (int i = 0; i < 6; i++) append(32767 - i, -32768 + 4000 * i);
    query(-1);
    send_item(MODE_CLEAR, 0, 0, 0);

    // random polygons, with a calm stretch and long receiver hold-offs
    while (items_sent < 370) begin
      calm = (items_sent > 150 && items_sent < 230);
      if (items_sent > 260 && items_sent < 270) hold_req = 1'b1;
      wide = ($urandom_range(0, 9) == 0);
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      rad = $urandom_range(16, 800);
      nv = $urandom_range(0, 10);
      nq = $urandom_range(2, 8);
      send_item(MODE_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < nv; i++) begin
        if (wide) append($urandom, $urandom);
        else append(cx + $urandom_range(0, 2 * rad) - rad,
                    cy + $urandom_range(0, 2 * rad) - rad);
      end
      for (int i = 0; i < nq; i++) begin
        if (wide || $urandom_range(0, 9) == 0) query($urandom_range(0, 4096) - 2048);
        else query((cy >>> 4) + $urandom_range(0, 2 * (rad >>> 4) + 4) - (rad >>> 4) - 2);
      end
      if ($urandom_range(0, 7) == 0) send_item(MODE_NOP, $urandom, $urandom, $urandom);
    end
    s_tvalid <= 1'b0;

    // drain, then allow the block to settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d items sent, %0d results matched, %0d spans, %0d dropped appends",
             items_sent, sb.matched, sb.spans, sb.overflows);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[convex_polygon_scanline_spans.f]
rtl/core/cps_pkg.sv
rtl/core/cps_ram.sv
rtl/core/cps_div.sv
rtl/core/cps_sort.sv
rtl/core/convex_polygon_scanline_spans.sv
tb/convex_polygon_scanline_spans_tb.sv
